>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL modules.
// Each macro expands to one labeled concurrent assertion on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

`endif

>>> hdl/srm_pkg.sv
// ----------------------------------------------------------------------------
// Step response metrics package
// Widths, selector codes, register indexes, shared types and helper functions.
// ----------------------------------------------------------------------------
package srm_pkg;

   // Field widths.
   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 24;
   localparam int AMP_BITS      = 16;
   localparam int OVS_BITS      = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   // Working widths: a difference of two values, and that times a percentage.
   localparam int WIDE_BITS = ((SAMPLE_BITS > AMP_BITS) ? SAMPLE_BITS : AMP_BITS) + 1;
   localparam int PCT_BITS  = 7;
   localparam int PROD_BITS = WIDE_BITS + PCT_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [OVS_BITS-1:0]   OVS_MAX   = '1;

   // Percentages used by the threshold compares.
   localparam logic [PCT_BITS-1:0] PCT_100 = 7'd100;
   localparam logic [PCT_BITS-1:0] PCT_95  = 7'd95;
   localparam logic [PCT_BITS-1:0] PCT_90  = 7'd90;
   localparam logic [PCT_BITS-1:0] PCT_10  = 7'd10;
   localparam logic [PCT_BITS-1:0] PCT_5   = 7'd5;
   localparam logic [PCT_BITS-1:0] PCT_2   = 7'd2;

   // Rise threshold selector codes.
   localparam logic [1:0] RISE_FULL = 2'd0;
   localparam logic [1:0] RISE_95   = 2'd1;

   // Settling band selector codes.
   localparam logic [1:0] BAND_2PCT = 2'd0;
   localparam logic [1:0] BAND_5PCT = 2'd1;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_STEP_AMPLITUDE = 3'd0,
      CSR_RISE_MODE      = 3'd1,
      CSR_RISING_STEP    = 3'd2,
      CSR_OVERSHOOT_MODE = 3'd3,
      CSR_SETTLE_BAND    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [AMP_BITS-1:0] step_amplitude;
      logic [1:0]                 rise_mode;
      logic                       rising_step;
      logic                       overshoot_mode;
      logic [1:0]                 settle_band;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          restart;
   } step_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] rise_time;
      logic [COUNT_BITS-1:0] peak_time;
      logic [OVS_BITS-1:0]   overshoot;
      logic [COUNT_BITS-1:0] settling_time;
      logic                  rise_done;
      logic                  peak_done;
      logic                  settle_active;
   } result_type;

   // Saturating tick counter increment.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
   endfunction

   // Signed value times an unsigned percentage, exact.
   function automatic logic signed [PROD_BITS-1:0] mul_pct(
      input logic signed [WIDE_BITS-1:0] v,
      input logic [PCT_BITS-1:0]         pct
   );
      logic signed [PROD_BITS-1:0] v_x;
      logic signed [PROD_BITS-1:0] p_x;
      v_x = PROD_BITS'(v);
      p_x = signed'(PROD_BITS'(pct));
      return v_x * p_x;
   endfunction

   // Absolute value; the operand never reaches the most negative code.
   function automatic logic signed [WIDE_BITS-1:0] abs_wide(
      input logic signed [WIDE_BITS-1:0] v
   );
      return v[WIDE_BITS-1] ? -v : v;
   endfunction

endpackage

>>> hdl/srm_core.sv
// ----------------------------------------------------------------------------
// Step response metrics core
// Holds the measurement state and updates it for one sample per enabled cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srm_core (
   input  logic               clock,
   input  logic               reset,
   input  srm_pkg::cfg_type   cfg,
   input  logic               step_en,
   input  srm_pkg::step_type  step,
   output srm_pkg::result_type result
);
   import srm_pkg::*;

   // Measurement state.
   logic signed [SAMPLE_BITS-1:0] prev_ff;
   logic [COUNT_BITS-1:0]         rise_cnt_ff, rise_cnt_in;
   logic [COUNT_BITS-1:0]         peak_cnt_ff, peak_cnt_in;
   logic [COUNT_BITS-1:0]         settle_cnt_ff, settle_cnt_in;
   logic                          rise_flag_ff, rise_flag_in;
   logic                          peak_flag_ff, peak_flag_in;
   logic                          settle_run_ff, settle_run_in;
   logic                          settle_armed_ff, settle_armed_in;
   logic signed [WIDE_BITS-1:0]   settle_slope_ff, settle_slope_in;
   logic [COUNT_BITS-1:0]         rise_res_ff, rise_res_in;
   logic [COUNT_BITS-1:0]         peak_res_ff, peak_res_in;
   logic [OVS_BITS-1:0]           ovs_res_ff, ovs_res_in;
   logic [COUNT_BITS-1:0]         settle_res_ff, settle_res_in;

   // Arithmetic on the incoming sample.
   logic signed [WIDE_BITS-1:0] s_w, a_w, prev_w, sc_w, diff_w, deriv_w, ovs_w;
   logic signed [PROD_BITS-1:0] sc_prod, rise_thr, err_prod, tol_prod;
   logic [PCT_BITS-1:0]         rise_pct, band_pct;
   logic [OVS_BITS-1:0]         ovs_sat;
   logic                        before_rise, turned, same_sign;

   assign s_w     = WIDE_BITS'(step.sample);
   assign a_w     = WIDE_BITS'(cfg.step_amplitude);
   assign prev_w  = WIDE_BITS'(prev_ff);
   assign sc_w    = s_w[WIDE_BITS-1] ? '0 : s_w;
   assign diff_w  = s_w - a_w;
   assign deriv_w = s_w - prev_w;

   // Percentage selection; unused codes mean 90 percent rise, 10 percent band.
   always_comb begin
      case (cfg.rise_mode)
         RISE_FULL: rise_pct = PCT_100;
         RISE_95:   rise_pct = PCT_95;
         default:   rise_pct = PCT_90;
      endcase
      case (cfg.settle_band)
         BAND_2PCT: band_pct = PCT_2;
         BAND_5PCT: band_pct = PCT_5;
         default:   band_pct = PCT_10;
      endcase
   end

   // Exact percentage compares, all scaled by one hundred.
   assign sc_prod  = mul_pct(sc_w, PCT_100);
   assign rise_thr = mul_pct(a_w, rise_pct);
   assign err_prod = mul_pct(abs_wide(diff_w), PCT_100);
   assign tol_prod = mul_pct(a_w, band_pct);

   assign before_rise = cfg.rising_step ? (sc_prod < rise_thr) : (sc_prod > rise_thr);
   assign turned      = cfg.rising_step ? (s_w < prev_w) : (s_w > prev_w);

   // Overshoot magnitude, saturated to the field width.
   assign ovs_w   = cfg.overshoot_mode ? abs_wide(s_w) : abs_wide(diff_w);
   assign ovs_sat = (|ovs_w[WIDE_BITS-1:OVS_BITS]) ? OVS_MAX : ovs_w[OVS_BITS-1:0];

   // Next state: restart clears, then rise, peak and settling in that order.
   always_comb begin
      if (step.restart) begin
         rise_cnt_in     = '0;
         peak_cnt_in     = '0;
         settle_cnt_in   = '0;
         rise_flag_in    = 1'b0;
         peak_flag_in    = 1'b0;
         settle_run_in   = 1'b0;
         settle_armed_in = 1'b1;
         settle_slope_in = '0;
         rise_res_in     = '0;
         peak_res_in     = '0;
         ovs_res_in      = '0;
         settle_res_in   = '0;
      end else begin
         rise_cnt_in     = rise_cnt_ff;
         peak_cnt_in     = peak_cnt_ff;
         settle_cnt_in   = settle_cnt_ff;
         rise_flag_in    = rise_flag_ff;
         peak_flag_in    = peak_flag_ff;
         settle_run_in   = settle_run_ff;
         settle_armed_in = settle_armed_ff;
         settle_slope_in = settle_slope_ff;
         rise_res_in     = rise_res_ff;
         peak_res_in     = peak_res_ff;
         ovs_res_in      = ovs_res_ff;
         settle_res_in   = settle_res_ff;
      end

      // Rise time.
      if (!rise_flag_in) begin
         if (before_rise) begin
            rise_cnt_in = sat_inc(rise_cnt_in);
         end else begin
            rise_flag_in = 1'b1;
            rise_res_in  = rise_cnt_in;
            rise_cnt_in  = '0;
         end
      end

      // Peak time and overshoot at the first turn after rise.
      if (!peak_flag_in) begin
         peak_cnt_in = sat_inc(peak_cnt_in);
      end
      if (rise_flag_in && !peak_flag_in && turned) begin
         peak_flag_in = 1'b1;
         peak_res_in  = peak_cnt_in;
         peak_cnt_in  = '0;
         ovs_res_in   = ovs_sat;
      end

      // Settling time against the tolerance band.
      same_sign = 1'b0;
      if (!settle_run_in && (err_prod >= tol_prod)) begin
         settle_run_in = 1'b1;
      end else if (settle_run_in) begin
         settle_cnt_in = sat_inc(settle_cnt_in);
         if ((err_prod <= tol_prod) && settle_armed_in) begin
            settle_res_in   = settle_cnt_in;
            settle_armed_in = 1'b0;
            settle_slope_in = deriv_w;
         end
         if (err_prod > tol_prod) begin
            settle_res_in   = settle_cnt_in;
            settle_armed_in = 1'b1;
         end
         same_sign = (settle_slope_in != '0) && (deriv_w != '0) &&
                     (settle_slope_in[WIDE_BITS-1] == deriv_w[WIDE_BITS-1]);
         if (((deriv_w == '0) || !same_sign) && !settle_armed_in) begin
            settle_run_in = 1'b0;
            settle_cnt_in = '0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff         <= '0;
         rise_cnt_ff     <= '0;
         peak_cnt_ff     <= '0;
         settle_cnt_ff   <= '0;
         rise_flag_ff    <= 1'b0;
         peak_flag_ff    <= 1'b0;
         settle_run_ff   <= 1'b0;
         settle_armed_ff <= 1'b1;
         settle_slope_ff <= '0;
         rise_res_ff     <= '0;
         peak_res_ff     <= '0;
         ovs_res_ff      <= '0;
         settle_res_ff   <= '0;
      end else if (step_en) begin
         prev_ff         <= step.sample;
         rise_cnt_ff     <= rise_cnt_in;
         peak_cnt_ff     <= peak_cnt_in;
         settle_cnt_ff   <= settle_cnt_in;
         rise_flag_ff    <= rise_flag_in;
         peak_flag_ff    <= peak_flag_in;
         settle_run_ff   <= settle_run_in;
         settle_armed_ff <= settle_armed_in;
         settle_slope_ff <= settle_slope_in;
         rise_res_ff     <= rise_res_in;
         peak_res_ff     <= peak_res_in;
         ovs_res_ff      <= ovs_res_in;
         settle_res_ff   <= settle_res_in;
      end
   end

   // The result of this beat is the updated state.
   assign result.rise_time     = rise_res_in;
   assign result.peak_time     = peak_res_in;
   assign result.overshoot     = ovs_res_in;
   assign result.settling_time = settle_res_in;
   assign result.rise_done     = rise_flag_in;
   assign result.peak_done     = peak_flag_in;
   assign result.settle_active = settle_run_in;

   // A peak is only taken after the rise threshold was crossed.
   `ASSERT_IMPLIES(a_peak_after_rise, clock, reset, peak_flag_ff, rise_flag_ff)
   // Counters are parked at zero once their measurement is latched.
   `ASSERT_IMPLIES(a_rise_cnt_parked, clock, reset, rise_flag_ff, rise_cnt_ff == '0)
   `ASSERT_IMPLIES(a_peak_cnt_parked, clock, reset, peak_flag_ff, peak_cnt_ff == '0)
   // The settling counter only runs while a settling measurement is active.
   `ASSERT_IMPLIES(a_settle_cnt_idle, clock, reset, !settle_run_ff, settle_cnt_ff == '0)

endmodule

>>> hdl/step_response_metrics.sv
// A result beat is registered as its sample beat leaves the sample register.
// Throughput: one sample per cycle; the whole state update is done in the single
// compute stage between the sample register and the result register.
// Backpressure on rsp stalls the sample register, which still takes a beat while
// it advances. Reset is synchronous and active high; it clears the measurements,
// the handshake state and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Step response metrics
// Measures rise time, peak time, overshoot and settling time of a sampled
// step response, one result beat per sample beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module step_response_metrics (
   input  logic                                clock,
   input  logic                                reset,
   // Sample channel. tdata: sample[15:0], restart[16], zero fill[23:17].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,
   // Result channel. tdata: rise_time[23:0], peak_time[47:24], overshoot[63:48],
   // settling_time[87:64], rise_done[88], peak_done[89], settle_active[90],
   // zero fill[95:91].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [95:0]                         rsp_tdata,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [srm_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [srm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import srm_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   step_type   in_step_ff;
   logic       out_valid_ff;
   logic [95:0] out_data_ff;
   logic       advance;
   result_type result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_amplitude <= '0;
         cfg_ff.rise_mode      <= RISE_FULL;
         cfg_ff.rising_step    <= 1'b1;
         cfg_ff.overshoot_mode <= 1'b0;
         cfg_ff.settle_band    <= BAND_2PCT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP_AMPLITUDE: cfg_ff.step_amplitude <= signed'(csr_wdata[AMP_BITS-1:0]);
            CSR_RISE_MODE:      cfg_ff.rise_mode      <= csr_wdata[1:0];
            CSR_RISING_STEP:    cfg_ff.rising_step    <= csr_wdata[0];
            CSR_OVERSHOOT_MODE: cfg_ff.overshoot_mode <= csr_wdata[0];
            CSR_SETTLE_BAND:    cfg_ff.settle_band    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // The compute stage moves when it holds a sample and the result register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Sample register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_step_ff.sample  <= signed'(req_tdata[SAMPLE_BITS-1:0]);
         in_step_ff.restart <= req_tdata[SAMPLE_BITS];
      end
   end

   srm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (advance),
      .step    (in_step_ff),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= {5'b0, result.settle_active, result.peak_done, result.rise_done,
                         result.settling_time, result.overshoot, result.peak_time,
                         result.rise_time};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // A sample beat only leaves the input register into a free result slot.
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, out_valid_ff && !rsp_tready, !advance)
   // A waiting sample with a free result slot is always consumed.
   `ASSERT_IMPLIES(a_no_bubble, clock, reset, in_valid_ff && !out_valid_ff, advance)

endmodule

>>> tb/step_response_metrics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step response metrics testbench
// Drives sample beats into step_response_metrics and checks every result beat
// against a cycle-free predictor of rise time, peak time, overshoot and
// settling time. A few directed traces probe the threshold boundaries and the
// value extremes. Shaped step responses under random settings and raw random
// samples follow. The sender idles in bursts and the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module step_response_metrics_tb;
   import srm_pkg::*;

   // Selector codes that the package leaves unnamed.
   localparam logic [1:0] RISE_SPARE   = 2'd3;
   localparam logic [1:0] BAND_SPARE   = 2'd3;
   localparam logic       STEP_FALLING = 1'b0;
   localparam logic       STEP_RISING  = 1'b1;
   localparam logic       OVS_TO_TARGET = 1'b0;
   localparam logic       OVS_ABSOLUTE  = 1'b1;

   // Cycles allowed for the pipeline to empty once nothing is expected.
   localparam int QUIET_CYCLES = 8;
   localparam int MAX_REPORTS  = 100;

   typedef enum int {
      READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE
   } ready_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata: sample[15:0], restart[16], zero fill[23:17].
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: rise_time[23:0], peak_time[47:24], overshoot[63:48],
   // settling_time[87:64], rise_done[88], peak_done[89], settle_active[90].
   logic [95:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Predicted results waiting for their beat, oldest first.
   result_type pending_metrics[$];

   int samples_sent    = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int settings_used   = 0;
   int burst_left      = 0;
   bit idle_on         = 1'b1;

   // Predictor copy of the configuration registers.
   logic signed [AMP_BITS-1:0] amp_cfg;
   logic [1:0]                 rise_sel;
   logic                       rising_cfg;
   logic                       ovs_abs_cfg;
   logic [1:0]                 band_sel;

   // Predictor copy of the measurement state.
   logic signed [SAMPLE_BITS-1:0] prev_sample;
   logic [COUNT_BITS-1:0]         rise_cnt, peak_cnt, settle_cnt;
   logic                          rise_seen, peak_seen, settling, settle_rearm;
   logic signed [SAMPLE_BITS:0]   settle_dir;
   logic [COUNT_BITS-1:0]         rise_lat, peak_lat, settle_lat;
   logic [OVS_BITS-1:0]           overshoot_lat;

   step_response_metrics dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("step_response_metrics verification failed");
      $finish;
   end

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return SAMPLE_BITS'(v);
   endfunction

   task automatic clear_metrics();
      rise_cnt = '0; peak_cnt = '0; settle_cnt = '0;
      rise_seen = 1'b0; peak_seen = 1'b0; settling = 1'b0;
      settle_rearm = 1'b1; settle_dir = '0;
      rise_lat = '0; peak_lat = '0; overshoot_lat = '0; settle_lat = '0;
   endtask

   task automatic reset_model();
      amp_cfg = '0;
      rise_sel = RISE_FULL;
      rising_cfg = STEP_RISING;
      ovs_abs_cfg = OVS_TO_TARGET;
      band_sel = BAND_2PCT;
      prev_sample = '0;
      clear_metrics();
   endtask

   // Advance the predicted measurement state by one sample.
   task automatic predict_metrics(input logic signed [SAMPLE_BITS-1:0] smp,
                                  input logic restart_bit, output result_type res);
      longint s, a, p, pct, band, sc, err, tol, deriv, ov;
      bit     early, turned, same;
      s = smp;
      a = amp_cfg;
      p = prev_sample;
      if (restart_bit) clear_metrics();

      // Rise: count until the clipped sample reaches the threshold.
      pct = (rise_sel == RISE_FULL) ? PCT_100 : (rise_sel == RISE_95) ? PCT_95 : PCT_90;
      if (!rise_seen) begin
         sc = (s < 0) ? 0 : s;
         early = rising_cfg ? (sc * 100 < a * pct) : (sc * 100 > a * pct);
         if (early) begin
            rise_cnt = bump(rise_cnt);
         end else begin
            rise_seen = 1'b1;
            rise_lat = rise_cnt;
            rise_cnt = '0;
         end
      end

      // Peak: the first turn of the slope after rise latches time and overshoot.
      if (!peak_seen) peak_cnt = bump(peak_cnt);
      if (rise_seen && !peak_seen) begin
         turned = rising_cfg ? (s < p) : (s > p);
         if (turned) begin
            peak_seen = 1'b1;
            peak_lat = peak_cnt;
            peak_cnt = '0;
            ov = ovs_abs_cfg ? magnitude(s) : magnitude(s - a);
            overshoot_lat = (ov > 65535) ? OVS_MAX : ov[OVS_BITS-1:0];
         end
      end

      // Settling: count while outside the band, stop once in band and the slope quits.
      band = (band_sel == BAND_2PCT) ? PCT_2 : (band_sel == BAND_5PCT) ? PCT_5 : PCT_10;
      err = magnitude(s - a) * 100;
      tol = a * band;
      deriv = s - p;
      if (!settling && err >= tol) begin
         settling = 1'b1;
      end else if (settling) begin
         settle_cnt = bump(settle_cnt);
         if (err <= tol && settle_rearm) begin
            settle_lat = settle_cnt;
            settle_rearm = 1'b0;
            settle_dir = deriv[SAMPLE_BITS:0];
         end
         if (err > tol) begin
            settle_lat = settle_cnt;
            settle_rearm = 1'b1;
         end
         same = (settle_dir != 0) && (deriv != 0) && ((settle_dir < 0) == (deriv < 0));
         if ((deriv == 0 || !same) && !settle_rearm) begin
            settling = 1'b0;
            settle_cnt = '0;
         end
      end
      prev_sample = smp;

      res.rise_time     = rise_lat;
      res.peak_time     = peak_lat;
      res.overshoot     = overshoot_lat;
      res.settling_time = settle_lat;
      res.rise_done     = rise_seen;
      res.peak_done     = peak_seen;
      res.settle_active = settling;
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Check one result beat against the oldest prediction.
   task automatic check_beat(input logic [95:0] beat);
      result_type want;
      if (pending_metrics.size() == 0) begin
         mismatches++;
         $display("%0t: result beat with nothing expected, actual %h", $time, beat);
      end else begin
         want = pending_metrics.pop_front();
         compare_field("rise_time", want.rise_time, beat[23:0]);
         compare_field("peak_time", want.peak_time, beat[47:24]);
         compare_field("overshoot", want.overshoot, beat[63:48]);
         compare_field("settling_time", want.settling_time, beat[87:64]);
         compare_field("rise_done", want.rise_done, beat[88]);
         compare_field("peak_done", want.peak_done, beat[89]);
         compare_field("settle_active", want.settle_active, beat[90]);
         results_checked++;
      end
   endtask

   // Result side: check accepted beats, then pick the next ready level.
   int              rsp_cycle = 0;
   ready_style_type rsp_style = READY_ALWAYS;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_beat(rsp_tdata);
         rsp_cycle++;
         if (rsp_cycle % 97 == 0) rsp_style = ready_style_type'($urandom_range(0, 3));
         case (rsp_style)
            READY_ALWAYS:   rsp_tready <= 1'b1;
            READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            READY_PERIODIC: rsp_tready <= (rsp_cycle % 5) != 0;
            default:        rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Send one sample beat, with a random gap between bursts when idling is on.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                              input logic restart_bit);
      result_type want;
      if (idle_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart_bit, smp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_metrics(smp, restart_bit, want);
      pending_metrics.push_back(want);
      samples_sent++;
   endtask

   // Hold the sender until every predicted beat has arrived and the pipe is quiet.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_metrics.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Write all five registers while the block is idle; spare upper bits are random.
   task automatic write_settings(input logic signed [AMP_BITS-1:0] amp,
                                 input logic [1:0] rsel, input logic dir,
                                 input logic osel, input logic [1:0] bsel);
      logic [CSR_DATA_BITS-1:0] val;
      drain_results();
      write_reg(CSR_STEP_AMPLITUDE, amp);
      val = 16'($urandom); val[1:0] = rsel;
      write_reg(CSR_RISE_MODE, val);
      val = 16'($urandom); val[0] = dir;
      write_reg(CSR_RISING_STEP, val);
      val = 16'($urandom); val[0] = osel;
      write_reg(CSR_OVERSHOOT_MODE, val);
      val = 16'($urandom); val[1:0] = bsel;
      write_reg(CSR_SETTLE_BAND, val);
      csr_we <= 1'b0;
      amp_cfg = amp; rise_sel = rsel; rising_cfg = dir;
      ovs_abs_cfg = osel; band_sel = bsel;
      settings_used++;
   endtask

   // Register defaults straight out of reset, no restart on the first beat.
   task automatic test_reset_defaults();
      int trace [0:4] = '{0, 5, 3, -2, 0};
      for (int i = 0; i < 5; i++) send_sample(16'(trace[i]), 1'b0);
   endtask

   // Rise exactly at 95 percent, band edge exactly at 5 percent, zero slope end.
   task automatic test_threshold_edges();
      int trace [0:7] = '{0, 949, 950, 1000, 1050, 1049, 1049, 1049};
      write_settings(16'sd1000, RISE_95, STEP_RISING, OVS_TO_TARGET, BAND_5PCT);
      for (int i = 0; i < 8; i++) send_sample(16'(trace[i]), i == 0);
   endtask

   // Full-scale samples and amplitudes, spare selector codes, falling sense.
   task automatic test_extreme_values();
      int up_trace [0:3]   = '{-32768, 32767, 32767, -32768};
      int down_trace [0:5] = '{0, -32768, -32768, 32767, 0, -1};
      write_settings(16'sh7fff, RISE_FULL, STEP_RISING, OVS_TO_TARGET, BAND_2PCT);
      for (int i = 0; i < 4; i++) send_sample(16'(up_trace[i]), i == 0);
      write_settings(16'sh8000, RISE_SPARE, STEP_FALLING, OVS_ABSOLUTE, BAND_SPARE);
      for (int i = 0; i < 6; i++) send_sample(16'(down_trace[i]), i == 0);
   endtask

   // Move linearly from one level to another with a little noise on each tick.
   task automatic glide(input longint from, input longint to, input int ticks,
                        input longint noise);
      longint v;
      for (int i = 1; i <= ticks; i++) begin
         v = from + (to - from) * i / ticks;
         if (noise > 0) v = v + longint'($urandom_range(0, 2 * noise)) - noise;
         send_sample(clamp_sample(v), 1'b0);
      end
   endtask

   // One shaped response: start on the far side, overshoot, ring down, settle.
   task automatic play_step_response();
      longint a, dir, span, lvl, dev, noise, nxt;
      a = amp_cfg;
      dir = rising_cfg ? 1 : -1;
      span = magnitude(a);
      if (span < 8) span = $urandom_range(8, 400);
      lvl = a - dir * span * longint'($urandom_range(80, 120)) / 100;
      dev = span * $urandom_range(0, 50) / 100;
      noise = ($urandom_range(0, 1) == 1) ? span / $urandom_range(100, 400) : 0;
      send_sample(clamp_sample(lvl), 1'b1);
      if ($urandom_range(0, 1) == 1) glide(lvl, lvl, $urandom_range(1, 3), 0);
      nxt = a + dir * dev;
      glide(lvl, nxt, $urandom_range(1, 10), noise);
      lvl = nxt;
      repeat ($urandom_range(0, 4)) begin
         dev = -dev / 2;
         nxt = a + dir * dev;
         glide(lvl, nxt, $urandom_range(1, 4), noise);
         if ($urandom_range(0, 2) == 0) glide(nxt, nxt, $urandom_range(1, 2), 0);
         lvl = nxt;
      end
      // Tail around the setpoint, sometimes flat.
      glide(lvl, a, $urandom_range(2, 12), noise);
   endtask

   // Well-formed step responses under random settings, extremes included.
   task automatic test_step_responses();
      logic signed [AMP_BITS-1:0] amp;
      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 3))
            0: amp = 16'($urandom_range(100, 30000));
            1: amp = -16'($urandom_range(100, 30000));
            2: amp = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
            default: amp = 16'($urandom_range(0, 16)) - 16'sd8;
         endcase
         write_settings(amp, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (3) play_step_response();
      end
   endtask

   // Unstructured samples and restarts under fully random settings.
   task automatic test_random_samples();
      for (int ph = 0; ph < 3; ph++) begin
         write_settings(16'($urandom), 2'($urandom), 1'($urandom),
                        1'($urandom), 2'($urandom));
         idle_on = ($urandom_range(0, 1) == 1);
         repeat (60) send_sample(16'($urandom), $urandom_range(0, 15) == 0);
      end
   endtask

   // Test sequence.
   initial begin
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_threshold_edges();
      test_extreme_values();
      test_step_responses();
      test_random_samples();
      drain_results();
      if (pending_metrics.size() != 0) begin
         mismatches++;
         $display("%0t: %0d predicted beats never arrived", $time, pending_metrics.size());
      end
      $display("Sent %0d samples under %0d register settings; compared %0d result beats.",
               samples_sent, settings_used, results_checked);
      $display("Settings spanned both step senses, all threshold and band codes, and",
               " full-scale amplitudes; %0d field mismatches.", mismatches);
      if (mismatches == 0) begin
         $display("step_response_metrics verification clean");
      end else begin
         $display("step_response_metrics verification failed");
      end
      $finish;
   end

endmodule
